FILE: rtl/ucv_pkg.sv
package ucv_pkg;

  localparam logic [15:0] UDP_PROTO_WORD = 16'd17;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [15:0] HDR_BYTES      = 16'd8;
  localparam logic [15:0] CSUM_HI        = 16'd6;
  localparam logic [15:0] CSUM_LO        = 16'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]  data;
    logic        seg_zero;
    logic        hdr_we;
    logic [2:0]  hdr_idx;
    logic        last;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] count;
    logic [63:0] header;
  } fin_t;

  typedef struct packed {
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_field;
    logic [15:0] stored_checksum;
    logic [15:0] computed_checksum;
    logic        checksum_good;
    logic        checksum_checked;
  } result_t;

  function automatic logic [15:0] add_ones(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/ucv_if.sv
interface ucv_byte_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, mode, data_byte, last, input ready);
  modport sink (input valid, mode, data_byte, last, output ready);
endinterface

interface ucv_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] length_field;
  logic [15:0] stored_checksum;
  logic [15:0] computed_checksum;
  logic        checksum_good;
  logic        checksum_checked;

  modport source (output valid, source_port, dest_port, length_field, stored_checksum,
                  computed_checksum, checksum_good, checksum_checked, input ready);
  modport sink (input valid, source_port, dest_port, length_field, stored_checksum,
                computed_checksum, checksum_good, checksum_checked, output ready);
endinterface

interface ucv_cfg_if;
  logic valid;
  logic ready;
  logic check_enable;

  modport source (output valid, check_enable, input ready);
  modport sink (input valid, check_enable, output ready);
endinterface

FILE: rtl/ucv_front.sv
module ucv_front import ucv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ucv_byte_if.sink byte_in,
  input  logic   q_ready,
  output logic   q_valid,
  output entry_t q_entry
);

  logic [15:0] count;
  logic [15:0] count_inc;
  logic        seg;
  logic        accept;

  assign seg       = byte_in.mode;
  assign count_inc = (count < COUNT_MAX) ? count + 16'd1 : count;
  assign accept    = byte_in.valid && q_ready;

  assign byte_in.ready = q_ready;
  assign q_valid       = byte_in.valid;

  always_comb begin
    q_entry.data     = byte_in.data_byte;
    q_entry.seg_zero = seg && (count == CSUM_HI || count == CSUM_LO);
    q_entry.hdr_we   = seg && (count < HDR_BYTES);
    q_entry.hdr_idx  = count[2:0];
    q_entry.last     = byte_in.last;
    q_entry.count    = seg ? count_inc : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (byte_in.last) begin
        count <= '0;
      end else if (seg) begin
        count <= count_inc;
      end
    end
  end

endmodule

FILE: rtl/ucv_queue.sv
module ucv_queue import ucv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_data
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                push;
  logic                pop;

  assign wr_ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/ucv_back.sv
module ucv_back import ucv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   check_enable,
  input  logic   rd_valid,
  output logic   rd_ready,
  input  entry_t rd_data,
  ucv_result_if.source result_out
);

  logic [15:0] acc;
  logic [7:0]  held;
  logic        odd;
  logic [63:0] header;
  logic [63:0] hdr_new;
  logic        fin_valid;
  fin_t        fin;
  result_t     res;
  logic        out_valid;

  logic        out_free;
  logic        fin_free;
  logic        pop;
  logic [7:0]  sum_byte;
  logic [15:0] word;
  logic [15:0] acc_add;
  logic [17:0] s3;
  logic [16:0] f1;
  logic [15:0] f2;
  logic [15:0] cmp;
  logic        enabled;

  assign out_free = !out_valid || result_out.ready;
  assign fin_free = !fin_valid || out_free;
  assign rd_ready = !rd_data.last || fin_free;
  assign pop      = rd_valid && rd_ready;

  assign sum_byte = rd_data.seg_zero ? 8'h00 : rd_data.data;
  assign word     = odd ? {held, sum_byte} : {sum_byte, 8'h00};
  assign acc_add  = add_ones(acc, word);

  always_comb begin
    hdr_new = header;
    for (int i = 0; i < 8; i++) begin
      if (rd_data.hdr_we && rd_data.hdr_idx == 3'(i)) begin
        hdr_new[8*(7-i) +: 8] = rd_data.data;
      end
    end
  end

  // The protocol word and the length are folded in with a three-input add.
  assign s3 = {2'b00, fin.sum} + {2'b00, fin.count} + {2'b00, UDP_PROTO_WORD};
  assign f1 = {1'b0, s3[15:0]} + {15'd0, s3[17:16]};
  assign f2 = f1[15:0] + {15'd0, f1[16]};
  assign cmp = (~f2 == 16'h0000) ? 16'hFFFF : ~f2;
  assign enabled = check_enable && (fin.count >= HDR_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held      <= '0;
      odd       <= 1'b0;
      header    <= '0;
      fin_valid <= 1'b0;
    end else begin
      if (pop && rd_data.last) begin
        fin_valid <= 1'b1;
      end else if (out_free) begin
        fin_valid <= 1'b0;
      end
      if (pop) begin
        if (rd_data.last) begin
          acc        <= '0;
          held       <= '0;
          odd        <= 1'b0;
          header     <= '0;
          fin.sum    <= acc_add;
          fin.count  <= rd_data.count;
          fin.header <= hdr_new;
        end else begin
          header <= hdr_new;
          if (odd) begin
            acc  <= acc_add;
            held <= '0;
            odd  <= 1'b0;
          end else begin
            held <= sum_byte;
            odd  <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      res.source_port       <= fin.header[63:48];
      res.dest_port         <= fin.header[47:32];
      res.length_field      <= fin.header[31:16];
      res.stored_checksum   <= fin.header[15:0];
      res.computed_checksum <= enabled ? cmp : 16'h0000;
      res.checksum_good     <= enabled && (cmp == fin.header[15:0]);
      res.checksum_checked  <= check_enable;
    end
  end

  assign result_out.valid             = out_valid;
  assign result_out.source_port       = res.source_port;
  assign result_out.dest_port         = res.dest_port;
  assign result_out.length_field      = res.length_field;
  assign result_out.stored_checksum   = res.stored_checksum;
  assign result_out.computed_checksum = res.computed_checksum;
  assign result_out.checksum_good     = res.checksum_good;
  assign result_out.checksum_checked  = res.checksum_checked;

endmodule

FILE: rtl/udp_checksum_verifier.sv
// Channel     Role   Beat
// byte_in     sink   mode, data_byte, last: one packet byte
// result_out  source header fields, computed checksum, flags: one per packet
// cfg         sink   check_enable write
//
// One byte is taken per cycle unless the queue is full; results pass through fin, then res.
// The rate is set by the single 16-bit end-around add in the accumulator.
// A four-entry queue separates byte classification from the accumulator, so
// a stalled result holds back input only once that queue has filled.
// Synchronous reset clears all packet state and sets check_enable to one.
module udp_checksum_verifier import ucv_pkg::*; (
  input logic clk,
  input logic rst,
  ucv_byte_if.sink     byte_in,
  ucv_result_if.source result_out,
  ucv_cfg_if.sink      cfg
);

  logic   check_enable;
  logic   q_wr_valid;
  logic   q_wr_ready;
  entry_t q_wr_data;
  logic   q_rd_valid;
  logic   q_rd_ready;
  entry_t q_rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b1;
    end else if (cfg.valid) begin
      check_enable <= cfg.check_enable;
    end
  end

  ucv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_ready (q_wr_ready),
    .q_valid (q_wr_valid),
    .q_entry (q_wr_data)
  );

  ucv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  ucv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .check_enable (check_enable),
    .rd_valid     (q_rd_valid),
    .rd_ready     (q_rd_ready),
    .rd_data      (q_rd_data),
    .result_out   (result_out)
  );

endmodule

FILE: rtl/ucv_checker.sv
module ucv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] stored_checksum,
  input logic [15:0] computed_checksum,
  input logic        checksum_good,
  input logic        checksum_checked
);

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid in the cycle after reset.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_good |-> checksum_checked && computed_checksum == stored_checksum)
    else $error("Good flag without a matching checked checksum.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_checked |-> computed_checksum == 16'h0000 && !checksum_good)
    else $error("Checksum reported while validation was off.");

endmodule

bind udp_checksum_verifier ucv_checker u_ucv_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .stored_checksum   (result_out.stored_checksum),
  .computed_checksum (result_out.computed_checksum),
  .checksum_good     (result_out.checksum_good),
  .checksum_checked  (result_out.checksum_checked)
);

FILE: tb/udp_checksum_verifier_tb.sv
module udp_checksum_verifier_tb;
  import ucv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AFTER    = 15;
  localparam int PHASE_ITEMS   = 376;

  typedef enum {CS_GOOD, CS_RANDOM, CS_ZERO} csum_fill_t;

  class checksum_scoreboard;
    bit          enable;
    logic [15:0] sum;
    logic [7:0]  held;
    bit          odd;
    logic [15:0] seg_count;
    logic [63:0] hdr;
    result_t     expected_q[$];
    int          errors;

    function new();
      enable = 1'b1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      sum = '0;
      held = '0;
      odd = 1'b0;
      seg_count = '0;
      hdr = '0;
    endfunction

    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [31:0] t;
      t = 32'(a) + 32'(b);
      return 16'(t[15:0] + t[31:16]);
    endfunction

    function void take_byte(logic [7:0] d);
      if (!odd) begin
        held = d;
        odd = 1'b1;
      end else begin
        sum = ones_add(sum, {held, d});
        held = '0;
        odd = 1'b0;
      end
    endfunction

    function bit advance(bit m, logic [7:0] d, bit l, output result_t r);
      logic [15:0] s;
      logic [15:0] idx;
      r = '0;
      if (m) begin
        idx = seg_count;
        if (idx < HDR_BYTES) hdr = hdr | ({56'd0, d} << (8 * (7 - idx)));
        if (seg_count != COUNT_MAX) seg_count = seg_count + 16'd1;
        take_byte((idx == CSUM_HI || idx == CSUM_LO) ? 8'h00 : d);
      end else begin
        take_byte(d);
      end
      if (!l) return 1'b0;
      s = sum;
      if (odd) s = ones_add(s, {held, 8'h00});
      s = ones_add(s, UDP_PROTO_WORD);
      s = ones_add(s, seg_count);
      r.source_port = hdr[63:48];
      r.dest_port = hdr[47:32];
      r.length_field = hdr[31:16];
      r.stored_checksum = hdr[15:0];
      r.checksum_checked = enable;
      if (enable && seg_count >= HDR_BYTES) begin
        r.computed_checksum = ~s;
        if (r.computed_checksum == 16'h0000) r.computed_checksum = 16'hFFFF;
        r.checksum_good = (r.computed_checksum == hdr[15:0]);
      end
      clear();
      return 1'b1;
    endfunction

    function void note_byte(bit m, logic [7:0] d, bit l);
      result_t r;
      if (advance(m, d, l, r)) expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, field, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("source_port", want.source_port, got.source_port);
      compare("dest_port", want.dest_port, got.dest_port);
      compare("length_field", want.length_field, got.length_field);
      compare("stored_checksum", want.stored_checksum, got.stored_checksum);
      compare("computed_checksum", want.computed_checksum, got.computed_checksum);
      compare("checksum_good", 16'(want.checksum_good), 16'(got.checksum_good));
      compare("checksum_checked", 16'(want.checksum_checked), 16'(got.checksum_checked));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ucv_byte_if   byte_in();
  ucv_result_if result_out();
  ucv_cfg_if    cfg();

  udp_checksum_verifier uut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .result_out(result_out),
    .cfg(cfg)
  );

  always #6 clk = ~clk;

  checksum_scoreboard sb = new();
  bit                 pk_mode[$];
  logic [7:0]         pk_data[$];
  bit                 quiet = 1'b0;
  int                 items_sent = 0;
  int                 results_taken = 0;
  int                 stall_cycles = 0;
  result_t            got;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.enable = cfg.check_enable;
      if (byte_in.valid && byte_in.ready)
        sb.note_byte(byte_in.mode, byte_in.data_byte, byte_in.last);
      if (result_out.valid && result_out.ready) begin
        got.source_port = result_out.source_port;
        got.dest_port = result_out.dest_port;
        got.length_field = result_out.length_field;
        got.stored_checksum = result_out.stored_checksum;
        got.computed_checksum = result_out.computed_checksum;
        got.checksum_good = result_out.checksum_good;
        got.checksum_checked = result_out.checksum_checked;
        sb.check_result(got);
        results_taken++;
      end
    end
    if ((cfg.valid && cfg.ready) || (byte_in.valid && byte_in.ready) ||
        (result_out.valid && result_out.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("udp_checksum_verifier verification failed");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block fills and stalls its input.
  initial begin
    bit held_off;
    held_off = 1'b0;
    result_out.ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result_out.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      result_out.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_byte(bit m, logic [7:0] d);
    pk_mode.push_back(m);
    pk_data.push_back(d);
  endfunction

  task automatic send_byte(bit m, logic [7:0] d, bit l);
    if (!quiet && $urandom_range(0, 15) == 0) begin
      byte_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.mode <= m;
    byte_in.data_byte <= d;
    byte_in.last <= l;
    do @(posedge clk); while (!byte_in.ready);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pk_mode.size(); i++) begin
      send_byte(pk_mode[i], pk_data[i], i == pk_mode.size() - 1);
      items_sent++;
    end
  endtask

  task automatic build_udp(int n_addr, int seg_len, csum_fill_t ck, int fill);
    logic [7:0]         hdr_b [8];
    logic [15:0]        len16;
    result_t            r;
    checksum_scoreboard probe;
    pk_mode.delete();
    pk_data.delete();
    for (int i = 0; i < n_addr; i++) push_byte(1'b0, fill < 0 ? rand_byte() : fill[7:0]);
    len16 = seg_len > 65535 ? 16'hFFFF : 16'(seg_len);
    for (int i = 0; i < 4; i++) hdr_b[i] = fill < 0 ? rand_byte() : fill[7:0];
    hdr_b[4] = len16[15:8];
    hdr_b[5] = len16[7:0];
    hdr_b[6] = 8'h00;
    hdr_b[7] = 8'h00;
    for (int i = 0; i < seg_len; i++) push_byte(1'b1, i < 8 ? hdr_b[i] : rand_byte());
    if (ck == CS_GOOD && seg_len >= 8) begin
      probe = new();
      for (int j = 0; j < pk_mode.size(); j++)
        void'(probe.advance(pk_mode[j], pk_data[j], j == pk_mode.size() - 1, r));
      pk_data[n_addr + 6] = r.computed_checksum[15:8];
      pk_data[n_addr + 7] = r.computed_checksum[7:0];
    end else if (ck == CS_RANDOM) begin
      if (seg_len > 6) pk_data[n_addr + 6] = rand_byte();
      if (seg_len > 7) pk_data[n_addr + 7] = rand_byte();
    end
  endtask

  task automatic random_packet();
    int         kind;
    int         n;
    int         j;
    csum_fill_t ck;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      n = $urandom_range(0, 9);
      ck = n < 6 ? CS_GOOD : (n < 8 ? CS_RANDOM : CS_ZERO);
      build_udp($urandom_range(0, 4) == 0 ? 32 : 8, $urandom_range(8, 48), ck, -1);
    end else if (kind < 75) begin
      build_udp(8, $urandom_range(0, 7), CS_RANDOM, -1);
    end else if (kind < 85) begin
      build_udp($urandom_range(0, 40), $urandom_range(0, 30), CS_RANDOM, -1);
      for (int k = 0; k < 3; k++) begin
        if (pk_mode.size() > 0) begin
          j = $urandom_range(0, pk_mode.size() - 1);
          pk_mode[j] = 1'b0;
        end
      end
    end else if (kind < 92) begin
      build_udp($urandom_range(0, 8), $urandom_range(0, 20), CS_RANDOM, -1);
      push_byte(1'b0, rand_byte());
    end else begin
      pk_mode.delete();
      pk_data.delete();
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) push_byte(1'(($urandom_range(0, 1))), rand_byte());
    end
    if (pk_mode.size() == 0) push_byte(1'b1, rand_byte());
    send_packet();
  endtask

  task automatic random_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_packet();
  endtask

  task automatic drain(int tail);
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_config(bit v);
    drain(10);
    cfg.check_enable <= v;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    byte_in.valid <= 1'b0;
    byte_in.mode <= 1'b0;
    byte_in.data_byte <= 8'h00;
    byte_in.last <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.check_enable <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    build_udp(8, 8, CS_GOOD, 255);
    send_packet();
    pk_mode.delete();
    pk_data.delete();
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h5A);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b1, 8'h00);
    send_packet();
    pk_mode.delete();
    pk_data.delete();
    push_byte(1'b0, 8'h80);
    send_packet();

    random_phase();
    write_config(1'b0);
    random_phase();
    write_config(1'b1);
    random_phase();
    write_config(1'b0);
    random_phase();
    write_config(1'b1);
    quiet = 1'b1;
    random_phase();

    drain(20);
    if (sb.errors == 0)
      $display("udp_checksum_verifier verification clean");
    else
      $display("udp_checksum_verifier verification failed");
    $finish;
  end

endmodule
